// File: rtl/core/bvpc_pkg.sv
package bvpc_pkg;

  localparam int VolW    = 7;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartVolume  = 3'd0,
    CfgMaxVolume    = 3'd1,
    CfgRepeatPeriod = 3'd2,
    CfgLongPress    = 3'd3,
    CfgDoubleWindow = 3'd4
  } cfg_idx_e;

  localparam logic [VolW-1:0] StartVolumeRst   = 7'd0;
  localparam logic [VolW-1:0] MaxVolumeRst     = 7'd21;
  localparam logic [CfgW-1:0] RepeatPeriodRst  = 16'd200;
  localparam logic [CfgW-1:0] LongPressRst     = 16'd1000;
  localparam logic [CfgW-1:0] DoubleWindowRst  = 16'd700;

  typedef struct packed {
    logic single_press;
    logic double_press;
    logic long_press;
  } evt_t;

endpackage

// File: rtl/core/button_volume_and_press_classifier.sv
// The result of an accepted tick is registered in the output register.
// Throughput: one tick per cycle; a tick is taken while the previous result
// waits, as long as the output register is free or being emptied.
// Reset (async, active low): registers to defaults, volume to 0, timers,
// button history and press flags cleared, output register empty.
module button_volume_and_press_classifier #(
  parameter int TIMER_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bvpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bvpc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         up_pressed_i,
  input  logic                         down_pressed_i,
  input  logic                         action_pressed_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bvpc_pkg::VolW-1:0]    volume_level_o,
  output logic                         volume_written_o,
  output logic                         limit_hit_o,
  output logic                         single_press_o,
  output logic                         double_press_o,
  output logic                         long_press_o
);
  import bvpc_pkg::*;

  logic [VolW-1:0] max_volume_q;
  logic [CfgW-1:0] repeat_period_q, long_press_q, double_window_q;

  logic            accept;
  logic            out_valid_q;
  logic            up_step, down_step;
  logic [VolW-1:0] volume_q, volume_d, vol_up;
  logic            limit_d;
  evt_t            evt;

  // start_volume is not stored here: writes to it are ignored, and reset returns the volume to 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_volume_q    <= MaxVolumeRst;
      repeat_period_q <= RepeatPeriodRst;
      long_press_q    <= LongPressRst;
      double_window_q <= DoubleWindowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMaxVolume:    max_volume_q    <= cfg_data_i[VolW-1:0];
        CfgRepeatPeriod: repeat_period_q <= cfg_data_i;
        CfgLongPress:    long_press_q    <= cfg_data_i;
        CfgDoubleWindow: double_window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  bvpc_vol_button #(.TIMER_BITS(TIMER_BITS)) u_up (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .level_i         (up_pressed_i),
    .repeat_period_i (repeat_period_q),
    .step_o          (up_step)
  );

  bvpc_vol_button #(.TIMER_BITS(TIMER_BITS)) u_down (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .level_i         (down_pressed_i),
    .repeat_period_i (repeat_period_q),
    .step_o          (down_step)
  );

  bvpc_action #(.TIMER_BITS(TIMER_BITS)) u_action (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .level_i           (action_pressed_i),
    .long_press_time_i (long_press_q),
    .double_window_i   (double_window_q),
    .evt_o             (evt)
  );

  // up first, then down
  always_comb begin
    limit_d = 1'b0;
    vol_up  = volume_q;
    if (up_step) begin
      if (({1'b0, volume_q} + 1'b1) > {1'b0, max_volume_q}) begin
        vol_up  = max_volume_q;
        limit_d = 1'b1;
      end else begin
        vol_up = volume_q + 1'b1;
      end
    end
    volume_d = vol_up;
    if (down_step) begin
      if (vol_up == '0) begin
        limit_d = 1'b1;
      end else begin
        volume_d = vol_up - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q    <= StartVolumeRst;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        volume_q    <= volume_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      volume_level_o   <= volume_d;
      volume_written_o <= up_step || down_step;
      limit_hit_o      <= limit_d;
      single_press_o   <= evt.single_press;
      double_press_o   <= evt.double_press;
      long_press_o     <= evt.long_press;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/bvpc_vol_button.sv
module bvpc_vol_button #(
  parameter int TIMER_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     level_i,
  input  logic [bvpc_pkg::CfgW-1:0] repeat_period_i,
  output logic                     step_o
);
  import bvpc_pkg::*;

  localparam int CmpW = (TIMER_BITS > CfgW) ? TIMER_BITS : CfgW;

  logic                  prev_q;
  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;

  assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;

  // step on a press edge, or on repeat while held past the period
  assign step_o = level_i &&
                  (!prev_q || (CmpW'(timer_inc) > CmpW'(repeat_period_i)));
  assign timer_d = step_o ? '0 : timer_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      timer_q <= '0;
    end else if (accept_i) begin
      prev_q  <= level_i;
      timer_q <= timer_d;
    end
  end

endmodule

// File: rtl/core/bvpc_action.sv
module bvpc_action #(
  parameter int TIMER_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      level_i,
  input  logic [bvpc_pkg::CfgW-1:0] long_press_time_i,
  input  logic [bvpc_pkg::CfgW-1:0] double_window_i,
  output bvpc_pkg::evt_t            evt_o
);
  import bvpc_pkg::*;

  localparam int CmpW = (TIMER_BITS > CfgW) ? TIMER_BITS : CfgW;

  logic                  prev_q;
  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
  logic                  wait_long_q, wait_long_d;
  logic                  wait_second_q, wait_second_d;
  logic                  fired_q, fired_d;
  logic [CmpW-1:0]       t_ext, lpt_ext, dw_ext;

  assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;
  assign t_ext     = CmpW'(timer_inc);
  assign lpt_ext   = CmpW'(long_press_time_i);
  assign dw_ext    = CmpW'(double_window_i);

  always_comb begin
    timer_d       = timer_inc;
    wait_long_d   = wait_long_q;
    wait_second_d = wait_second_q;
    fired_d       = fired_q;
    evt_o         = '0;
    if (level_i != prev_q) begin
      if (level_i && !wait_second_q) begin
        timer_d     = '0;
        wait_long_d = 1'b1;
      end
      if (level_i && wait_second_q && (dw_ext > t_ext)) begin
        wait_second_d      = 1'b0;
        wait_long_d        = 1'b0;
        fired_d            = 1'b1;
        evt_o.double_press = 1'b1;
      end
      if (!level_i) begin
        if (!fired_q) begin
          wait_second_d = 1'b1;
          wait_long_d   = 1'b0;
        end
        fired_d = 1'b0;
      end
    end else begin
      if (level_i && wait_long_q && (t_ext >= lpt_ext)) begin
        wait_second_d    = 1'b0;
        wait_long_d      = 1'b0;
        fired_d          = 1'b1;
        evt_o.long_press = 1'b1;
      end
      if (!level_i && wait_second_q && (dw_ext < t_ext)) begin
        wait_second_d      = 1'b0;
        wait_long_d        = 1'b0;
        evt_o.single_press = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q        <= 1'b0;
      timer_q       <= '0;
      wait_long_q   <= 1'b0;
      wait_second_q <= 1'b0;
      fired_q       <= 1'b0;
    end else if (accept_i) begin
      prev_q        <= level_i;
      timer_q       <= timer_d;
      wait_long_q   <= wait_long_d;
      wait_second_q <= wait_second_d;
      fired_q       <= fired_d;
    end
  end

endmodule

// File: sim/button_volume_and_press_classifier_test.sv
module button_volume_and_press_classifier_test;
  import bvpc_pkg::*;

  typedef struct packed {
    logic [VolW-1:0] volume_level;
    logic            volume_written;
    logic            limit_hit;
    logic            single_press;
    logic            double_press;
    logic            long_press;
  } tick_result_t;

  class volume_press_tracker;
    localparam int TimerW = 16;

    logic [VolW-1:0]   start_volume;
    logic [VolW-1:0]   max_volume;
    logic [TimerW-1:0] repeat_period;
    logic [TimerW-1:0] long_press_time;
    logic [TimerW-1:0] double_window;

    logic [VolW-1:0]   volume;
    bit                up_prev;
    bit                down_prev;
    bit                action_prev;
    logic [TimerW-1:0] up_timer;
    logic [TimerW-1:0] down_timer;
    logic [TimerW-1:0] action_timer;
    bit                waiting_long;
    bit                waiting_second;
    bit                event_fired;

    tick_result_t pending_results[$];
    int unsigned  errors;

    function new();
      start_volume    = StartVolumeRst;
      max_volume      = MaxVolumeRst;
      repeat_period   = RepeatPeriodRst;
      long_press_time = LongPressRst;
      double_window   = DoubleWindowRst;
      volume          = StartVolumeRst;
      up_prev         = 1'b0;
      down_prev       = 1'b0;
      action_prev     = 1'b0;
      up_timer        = '0;
      down_timer      = '0;
      action_timer    = '0;
      waiting_long    = 1'b0;
      waiting_second  = 1'b0;
      event_fired     = 1'b0;
      errors          = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] d);
      case (idx)
        CfgStartVolume:  start_volume    = d[VolW-1:0];
        CfgMaxVolume:    max_volume      = d[VolW-1:0];
        CfgRepeatPeriod: repeat_period   = d;
        CfgLongPress:    long_press_time = d;
        CfgDoubleWindow: double_window   = d;
        default: ;
      endcase
    endfunction

    function logic [TimerW-1:0] bump(logic [TimerW-1:0] t);
      return (t == '1) ? t : t + 1'b1;
    endfunction

    function void take_tick(bit up, bit dn, bit act);
      tick_result_t r;
      bit up_step;
      bit dn_step;
      r = '0;
      up_timer     = bump(up_timer);
      down_timer   = bump(down_timer);
      action_timer = bump(action_timer);

      up_step = up && (!up_prev || up_timer > repeat_period);
      if (up_step) begin
        up_timer = '0;
        if (int'(volume) + 1 > int'(max_volume)) begin
          volume      = max_volume;
          r.limit_hit = 1'b1;
        end else begin
          volume = volume + 1'b1;
        end
      end
      up_prev = up;

      dn_step = dn && (!down_prev || down_timer > repeat_period);
      if (dn_step) begin
        down_timer = '0;
        if (volume == '0) r.limit_hit = 1'b1;
        else volume = volume - 1'b1;
      end
      down_prev = dn;
      r.volume_written = up_step || dn_step;

      if (act != action_prev) begin
        if (act && !waiting_second) begin
          action_timer = '0;
          waiting_long = 1'b1;
        end
        if (act && waiting_second && double_window > action_timer) begin
          waiting_second = 1'b0;
          waiting_long   = 1'b0;
          event_fired    = 1'b1;
          r.double_press = 1'b1;
        end
        if (!act && !event_fired) begin
          waiting_second = 1'b1;
          waiting_long   = 1'b0;
        end
        if (!act) event_fired = 1'b0;
      end else begin
        if (act && waiting_long && action_timer >= long_press_time) begin
          waiting_second = 1'b0;
          waiting_long   = 1'b0;
          event_fired    = 1'b1;
          r.long_press   = 1'b1;
        end
        if (!act && waiting_second && double_window < action_timer) begin
          waiting_second = 1'b0;
          waiting_long   = 1'b0;
          r.single_press = 1'b1;
        end
      end
      action_prev = act;

      r.volume_level = volume;
      pending_results.push_back(r);
    endfunction

    function void match_result(tick_result_t got);
      tick_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no tick pending");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.volume_level !== want.volume_level) begin
        $error("volume_level: expected %0d, got %0d", want.volume_level, got.volume_level);
        errors++;
      end
      if (got.volume_written !== want.volume_written) begin
        $error("volume_written: expected %0b, got %0b", want.volume_written,
               got.volume_written);
        errors++;
      end
      if (got.limit_hit !== want.limit_hit) begin
        $error("limit_hit: expected %0b, got %0b", want.limit_hit, got.limit_hit);
        errors++;
      end
      if (got.single_press !== want.single_press) begin
        $error("single_press: expected %0b, got %0b", want.single_press,
               got.single_press);
        errors++;
      end
      if (got.double_press !== want.double_press) begin
        $error("double_press: expected %0b, got %0b", want.double_press,
               got.double_press);
        errors++;
      end
      if (got.long_press !== want.long_press) begin
        $error("long_press: expected %0b, got %0b", want.long_press, got.long_press);
        errors++;
      end
    endfunction
  endclass

  localparam int QuietLimit = 4000;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i        = '0;
  logic [CfgW-1:0]    cfg_data_i       = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic               up_pressed_i     = 1'b0;
  logic               down_pressed_i   = 1'b0;
  logic               action_pressed_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [VolW-1:0]    volume_level_o;
  logic               volume_written_o;
  logic               limit_hit_o;
  logic               single_press_o;
  logic               double_press_o;
  logic               long_press_o;

  volume_press_tracker tracker;
  int unsigned         src_idle_pct  = 0;
  int unsigned         rcv_stall_pct = 0;
  int unsigned         quiet_cycles  = 0;

  button_volume_and_press_classifier u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .up_pressed_i     (up_pressed_i),
    .down_pressed_i   (down_pressed_i),
    .action_pressed_i (action_pressed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .volume_level_o   (volume_level_o),
    .volume_written_o (volume_written_o),
    .limit_hit_o      (limit_hit_o),
    .single_press_o   (single_press_o),
    .double_press_o   (double_press_o),
    .long_press_o     (long_press_o)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    tick_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.volume_level   = volume_level_o;
      got.volume_written = volume_written_o;
      got.limit_hit      = limit_hit_o;
      got.single_press   = single_press_o;
      got.double_press   = double_press_o;
      got.long_press     = long_press_o;
      tracker.match_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic drive_tick(bit up, bit dn, bit act);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    up_pressed_i     <= up;
    down_pressed_i   <= dn;
    action_pressed_i <= act;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_tick(up, dn, act);
    @(negedge clk_i);
  endtask

  task automatic hold(bit up, bit dn, bit act, int unsigned n);
    repeat (n) drive_tick(up, dn, act);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    tracker.set_reg(idx, d);
    @(negedge clk_i);
  endtask

  task automatic load_config(logic [VolW-1:0] sv, logic [VolW-1:0] mv,
                             logic [CfgW-1:0] rp, logic [CfgW-1:0] lp,
                             logic [CfgW-1:0] dw);
    write_reg(CfgStartVolume, CfgW'(sv));
    write_reg(CfgMaxVolume, CfgW'(mv));
    write_reg(CfgRepeatPeriod, rp);
    write_reg(CfgLongPress, lp);
    write_reg(CfgDoubleWindow, dw);
    cfg_we_i <= 1'b0;
  endtask

  // button levels flip at a rate that changes in bursts
  task automatic random_ticks(int unsigned n);
    bit          up;
    bit          dn;
    bit          act;
    int unsigned flip;
    up   = 1'b0;
    dn   = 1'b0;
    act  = 1'b0;
    flip = 25;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0)
        flip = ($urandom_range(3) == 0) ? 60 : $urandom_range(30, 3);
      if ($urandom_range(99) < flip) up = !up;
      if ($urandom_range(99) < flip) dn = !dn;
      if ($urandom_range(99) < flip) act = !act;
      drive_tick(up, dn, act);
    end
  endtask

  initial begin
    int unsigned idle_src[4];
    int unsigned idle_rcv[4];
    idle_src = '{0, 75, 0, 34};
    idle_rcv = '{0, 0, 75, 34};
    tracker = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling
    load_config(7'd127, 7'd127, 16'd0, 16'd2, 16'd3);
    hold(1, 0, 0, 130);                     // climb to the top and clamp
    settle();
    load_config(7'd0, 7'd5, 16'd0, 16'd2, 16'd3);
    hold(0, 0, 0, 1);
    hold(1, 0, 0, 1);                       // up from above max
    hold(1, 1, 0, 1);                       // both at once
    hold(0, 1, 0, 8);                       // down into zero
    hold(0, 0, 1, 1); hold(0, 0, 0, 5);     // single
    hold(0, 0, 1, 1); hold(0, 0, 0, 1);
    hold(0, 0, 1, 1); hold(0, 0, 0, 1);     // double
    hold(0, 0, 1, 4); hold(0, 0, 0, 1);     // long
    hold(0, 0, 1, 1); hold(0, 0, 0, 3);
    hold(0, 0, 1, 1); hold(0, 0, 0, 5);     // late second press
    settle();
    load_config(7'd0, 7'd0, 16'd0, 16'd0, 16'd0);
    random_ticks(20);
    settle();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = idle_src[p];
      rcv_stall_pct = idle_rcv[p];
      repeat (2) begin
        settle();
        load_config(7'($urandom_range(127)), 7'($urandom_range(127)),
                    16'($urandom_range(6)), 16'($urandom_range(10)),
                    16'($urandom_range(8)));
        random_ticks(32);
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bvpc_pkg.sv
rtl/core/bvpc_vol_button.sv
rtl/core/bvpc_action.sv
rtl/core/button_volume_and_press_classifier.sv
sim/button_volume_and_press_classifier_test.sv
